/* rtl/scc_pkg.sv */
// package for the short-name case classifier
// holds byte kinds, result type and limits; no dependencies
`timescale 1ns / 1ps

package scc_pkg;

    // default saturation point of the part counters
    localparam int C_MAX_LEN = 255;

    // longest name and extension parts that still fit a short name
    localparam int C_NAME_LIMIT = 8;
    localparam int C_EXT_LIMIT  = 3;

    // flag codes in the result
    localparam logic [7:0] C_FLAGS_INVALID = 8'hFF;
    localparam logic [7:0] C_FLAGS_LONG    = 8'h00;
    localparam logic [7:0] C_FLAG_NAME_LC  = 8'h08;
    localparam logic [7:0] C_FLAG_EXT_LC   = 8'h10;

    // class of one name byte
    typedef enum logic [2:0] {
        K_NEUTRAL,
        K_INVALID,
        K_DOT,
        K_FORCE_LONG,
        K_UPPER,
        K_LOWER
    } t_byte_kind;

    // one classification result
    typedef struct packed {
        logic [7:0] case_flags;
        logic [7:0] name_length;
        logic [7:0] ext_length;
    } t_result;

endpackage

/* rtl/scc_in_if.sv */
// byte channel into the short-name case classifier
// one name byte and its end marker per beat; no dependencies
`timescale 1ns / 1ps

interface scc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

/* rtl/scc_out_if.sv */
// result channel out of the short-name case classifier
// flags and part lengths per beat; no dependencies
`timescale 1ns / 1ps

interface scc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] case_flags;
    logic [7:0] name_length;
    logic [7:0] ext_length;

    modport source (output valid, output case_flags, output name_length,
                    output ext_length, input ready);
    modport sink   (input valid, input case_flags, input name_length,
                    input ext_length, output ready);
endinterface

/* rtl/scc_byte_class.sv */
// byte decoder: sorts one file name byte into its class
// depends on scc_pkg
`timescale 1ns / 1ps

module scc_byte_class (
    input  logic [7:0]          i_ch,
    output scc_pkg::t_byte_kind o_kind
);

    // control bytes, DEL and " * / : < > ? \ | are invalid
    // space + , ; = [ ] force a long name; bytes 0x80 and up are neutral
    always_comb begin
        unique case (i_ch) inside
            [8'h00:8'h1F], 8'h7F, 8'h22, 8'h2A, 8'h2F, 8'h3A, 8'h3C, 8'h3E,
            8'h3F, 8'h5C, 8'h7C: begin
                o_kind = scc_pkg::K_INVALID;
            end
            8'h2E: begin
                o_kind = scc_pkg::K_DOT;
            end
            8'h20, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h5B, 8'h5D: begin
                o_kind = scc_pkg::K_FORCE_LONG;
            end
            [8'h41:8'h5A]: begin
                o_kind = scc_pkg::K_UPPER;
            end
            [8'h61:8'h7A]: begin
                o_kind = scc_pkg::K_LOWER;
            end
            default: begin
                o_kind = scc_pkg::K_NEUTRAL;
            end
        endcase
    end

endmodule

/* rtl/scc_tracker.sv */
// name state tracker: part counters, case flags and result formation
// depends on scc_pkg
`timescale 1ns / 1ps

module scc_tracker #(
    parameter int MAX_LEN = scc_pkg::C_MAX_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  scc_pkg::t_byte_kind i_kind,
    input  logic                i_last,
    output scc_pkg::t_result    o_result
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    logic             r_in_ext,     n_in_ext;
    logic [CNT_W-1:0] r_name_cnt,   n_name_cnt;
    logic [CNT_W-1:0] r_ext_cnt,    n_ext_cnt;
    logic             r_name_upper, n_name_upper;
    logic             r_name_lower, n_name_lower;
    logic             r_ext_upper,  n_ext_upper;
    logic             r_ext_lower,  n_ext_lower;
    logic             r_long,       n_long;
    logic             r_invalid,    n_invalid;
    logic [CNT_W-1:0] s_name_bump,  s_ext_bump;

    // saturating increments
    assign s_name_bump = (r_name_cnt == CNT_MAX) ? r_name_cnt : r_name_cnt + 1'b1;
    assign s_ext_bump  = (r_ext_cnt == CNT_MAX) ? r_ext_cnt : r_ext_cnt + 1'b1;

    // state after this byte
    always_comb begin
        n_in_ext     = r_in_ext;
        n_name_cnt   = r_name_cnt;
        n_ext_cnt    = r_ext_cnt;
        n_name_upper = r_name_upper;
        n_name_lower = r_name_lower;
        n_ext_upper  = r_ext_upper;
        n_ext_lower  = r_ext_lower;
        n_long       = r_long;
        n_invalid    = r_invalid;
        if (!r_invalid) begin
            if (i_kind == scc_pkg::K_INVALID) begin
                n_invalid = 1'b1;
            end else if (!r_in_ext) begin
                if (i_kind == scc_pkg::K_DOT) begin
                    n_in_ext = 1'b1;
                end else begin
                    n_name_cnt = s_name_bump;
                    case (i_kind)
                        scc_pkg::K_FORCE_LONG: n_long       = 1'b1;
                        scc_pkg::K_UPPER:      n_name_upper = 1'b1;
                        scc_pkg::K_LOWER:      n_name_lower = 1'b1;
                        default:               n_long       = r_long;
                    endcase
                end
            end else begin
                n_ext_cnt = s_ext_bump;
                case (i_kind)
                    scc_pkg::K_DOT, scc_pkg::K_FORCE_LONG: n_long      = 1'b1;
                    scc_pkg::K_UPPER:                      n_ext_upper = 1'b1;
                    scc_pkg::K_LOWER:                      n_ext_lower = 1'b1;
                    default:                               n_long      = r_long;
                endcase
            end
        end
    end

    // classification of the name as it stands after this byte
    always_comb begin
        o_result.name_length = 8'(n_name_cnt);
        o_result.ext_length  = 8'(n_ext_cnt);
        if (n_invalid) begin
            o_result.case_flags = scc_pkg::C_FLAGS_INVALID;
        end else if (n_long
                     || (n_name_cnt > CNT_W'(scc_pkg::C_NAME_LIMIT))
                     || (n_ext_cnt > CNT_W'(scc_pkg::C_EXT_LIMIT))
                     || (n_name_upper && n_name_lower)
                     || (n_ext_upper && n_ext_lower)) begin
            o_result.case_flags = scc_pkg::C_FLAGS_LONG;
        end else begin
            o_result.case_flags = (n_name_upper ? 8'h00 : scc_pkg::C_FLAG_NAME_LC)
                                | (n_ext_upper ? 8'h00 : scc_pkg::C_FLAG_EXT_LC);
        end
    end

    // state registers; the final byte of a name clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_in_ext     <= 1'b0;
            r_name_cnt   <= '0;
            r_ext_cnt    <= '0;
            r_name_upper <= 1'b0;
            r_name_lower <= 1'b0;
            r_ext_upper  <= 1'b0;
            r_ext_lower  <= 1'b0;
            r_long       <= 1'b0;
            r_invalid    <= 1'b0;
        end else if (i_step) begin
            r_in_ext     <= n_in_ext;
            r_name_cnt   <= n_name_cnt;
            r_ext_cnt    <= n_ext_cnt;
            r_name_upper <= n_name_upper;
            r_name_lower <= n_name_lower;
            r_ext_upper  <= n_ext_upper;
            r_ext_lower  <= n_ext_lower;
            r_long       <= n_long;
            r_invalid    <= n_invalid;
        end
    end

    // a finished name leaves the tracker empty
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_name_cnt == '0 && r_ext_cnt == '0 && !r_in_ext
                                && !r_invalid && !r_long))
        else $error("tracker not cleared after final byte");

    // counters never pass the saturation point
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_name_cnt <= CNT_MAX) && (r_ext_cnt <= CNT_MAX))
        else $error("part counter beyond saturation");

    // an invalid byte sticks until the name ends
    a_invalid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_last && r_invalid) |=> r_invalid)
        else $error("invalid mark lost within a name");

endmodule

/* rtl/short_name_case_classifier.sv */
// top level of the short-name case classifier
// depends on scc_pkg, scc_in_if, scc_out_if, scc_byte_class, scc_tracker
`timescale 1ns / 1ps

// Classifies a file name for FAT 8.3 short-name use.
// i_in carries one name byte per beat (ch), with last set on the final byte.
// o_out carries one beat per name: case_flags (0xFF invalid, 0x00 long name
// needed, else bit 3 = name part has no uppercase, bit 4 = extension part has
// no uppercase), name_length and ext_length (saturating at MAX_LEN).
// Bytes without last produce no result beat.
// A final byte accepted into the byte register is classified there and its
// result is loaded into the result register as the byte stage advances, so
// the result beat reaches o_out from the result register.
// Throughput: one byte per cycle while i_in.ready is high; the byte and result
// registers are separate stages, so bytes keep flowing while a result waits.
// When the receiver stalls, the result register holds; non-final bytes still
// pass, and only a second final byte waits in the byte register, which then
// drops i_in.ready until the pending result is taken.
// Reset (synchronous, active low) empties both stages and clears all
// per-name state; the block takes bytes in the first cycle after reset.
module short_name_case_classifier #(
    parameter int MAX_LEN = scc_pkg::C_MAX_LEN
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    scc_in_if.sink   i_in,
    scc_out_if.source o_out
);

    logic                r_in_valid;
    logic [7:0]          r_ch;
    logic                r_last;
    logic                r_out_valid;
    scc_pkg::t_result    r_res;
    scc_pkg::t_byte_kind s_kind;
    scc_pkg::t_result    s_result;
    logic                s_advance;
    logic                s_load;

    // the byte stage moves on unless it holds a final byte facing a full,
    // stalled result register
    assign s_advance = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign s_load    = s_advance && r_last;
    assign i_in.ready = !r_in_valid || s_advance;

    // byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch   <= i_in.ch;
            r_last <= i_in.last;
        end
    end

    // byte decode
    scc_byte_class u_byte_class (
        .i_ch   (r_ch),
        .o_kind (s_kind)
    );

    // per-name state and result
    scc_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_advance),
        .i_kind   (s_kind),
        .i_last   (r_last),
        .o_result (s_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_res <= s_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.case_flags  = r_res.case_flags;
    assign o_out.name_length = r_res.name_length;
    assign o_out.ext_length  = r_res.ext_length;

    // a final byte taken in lands in the byte register
    a_last_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last) |=> (r_in_valid && r_last))
        else $error("final byte not captured");

    // a final byte behind a stalled result stays put
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_last && r_out_valid && !o_out.ready) |=> (r_in_valid && r_last))
        else $error("final byte lost while result stalled");

    // flags are either the invalid code or only the lowercase hint bits
    a_flags_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.case_flags == scc_pkg::C_FLAGS_INVALID)
                         || ((r_res.case_flags & ~(scc_pkg::C_FLAG_NAME_LC
                                                 | scc_pkg::C_FLAG_EXT_LC)) == 8'h00)))
        else $error("malformed case flags");

endmodule

/* sim/tb_short_name_case_classifier.sv */
// testbench for the short-name case classifier: byte beats in, one verdict per name out
// depends on scc_pkg, scc_in_if, scc_out_if and the short_name_case_classifier rtl
`timescale 1ns / 1ps

module tb_short_name_case_classifier;

    localparam int MAX_LEN      = scc_pkg::C_MAX_LEN;
    localparam int RANDOM_BYTES = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    // sender idle and receiver stall percentages, one pair per phase
    localparam int IN_IDLE[4]   = '{0, 63, 0, 9};
    localparam int OUT_STALL[4] = '{0, 0, 63, 9};

    // case style of one part of a generated name
    typedef enum int {
        CASE_UPPER,
        CASE_LOWER,
        CASE_MIXED
    } t_part_case;

    // tracks the name in flight and holds the verdicts still owed by the block
    class short_name_checker;
        int unsigned      max_len;
        bit               in_ext;
        bit               name_upper;
        bit               name_lower;
        bit               ext_upper;
        bit               ext_lower;
        bit               long_needed;
        bit               bad_name;
        int unsigned      name_cnt;
        int unsigned      ext_cnt;
        scc_pkg::t_result expected_verdicts[$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      invalid_seen;
        int unsigned      long_seen;
        int unsigned      short_seen;

        function new(int unsigned max_len_i);
            max_len = max_len_i;
            clear_name();
        endfunction

        function void clear_name();
            in_ext      = 1'b0;
            name_upper  = 1'b0;
            name_lower  = 1'b0;
            ext_upper   = 1'b0;
            ext_lower   = 1'b0;
            long_needed = 1'b0;
            bad_name    = 1'b0;
            name_cnt    = 0;
            ext_cnt     = 0;
        endfunction

        function int unsigned bump(int unsigned v);
            return (v < max_len) ? v + 1 : max_len;
        endfunction

        function scc_pkg::t_byte_kind kind_of(logic [7:0] c);
            if (c < 8'h20 || c == 8'h7F)
                return scc_pkg::K_INVALID;
            if (c >= "A" && c <= "Z")
                return scc_pkg::K_UPPER;
            if (c >= "a" && c <= "z")
                return scc_pkg::K_LOWER;
            // double quote and backslash given by code
            case (c)
                8'h22, "*", "/", ":", "<", ">", "?", 8'h5C, "|": return scc_pkg::K_INVALID;
                ".":                                return scc_pkg::K_DOT;
                " ", "+", ",", ";", "=", "[", "]":  return scc_pkg::K_FORCE_LONG;
                default:                            return scc_pkg::K_NEUTRAL;
            endcase
        endfunction

        // one accepted byte beat; the final byte of a name owes a verdict
        function void add_byte(logic [7:0] c, logic fin);
            scc_pkg::t_byte_kind k;
            scc_pkg::t_result    v;
            k = kind_of(c);
            if (!bad_name) begin
                if (k == scc_pkg::K_INVALID) begin
                    bad_name = 1'b1;
                end else if (!in_ext && k == scc_pkg::K_DOT) begin
                    in_ext = 1'b1;
                end else if (!in_ext) begin
                    name_cnt = bump(name_cnt);
                    if (k == scc_pkg::K_FORCE_LONG)
                        long_needed = 1'b1;
                    else if (k == scc_pkg::K_UPPER)
                        name_upper = 1'b1;
                    else if (k == scc_pkg::K_LOWER)
                        name_lower = 1'b1;
                end else begin
                    ext_cnt = bump(ext_cnt);
                    if (k == scc_pkg::K_FORCE_LONG || k == scc_pkg::K_DOT)
                        long_needed = 1'b1;
                    else if (k == scc_pkg::K_UPPER)
                        ext_upper = 1'b1;
                    else if (k == scc_pkg::K_LOWER)
                        ext_lower = 1'b1;
                end
            end
            if (fin) begin
                if (bad_name)
                    v.case_flags = scc_pkg::C_FLAGS_INVALID;
                else if (long_needed || name_cnt > scc_pkg::C_NAME_LIMIT
                         || ext_cnt > scc_pkg::C_EXT_LIMIT
                         || (name_upper && name_lower) || (ext_upper && ext_lower))
                    v.case_flags = scc_pkg::C_FLAGS_LONG;
                else
                    v.case_flags = (name_upper ? 8'h00 : scc_pkg::C_FLAG_NAME_LC) |
                                   (ext_upper  ? 8'h00 : scc_pkg::C_FLAG_EXT_LC);
                v.name_length = 8'(name_cnt);
                v.ext_length  = 8'(ext_cnt);
                expected_verdicts.push_back(v);
                clear_name();
            end
        endfunction

        // one accepted result beat against the oldest verdict owed
        function void check_verdict(scc_pkg::t_result got);
            scc_pkg::t_result want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected verdict: flags %02h name %0d ext %0d",
                             got.case_flags, got.name_length, got.ext_length);
            end else begin
                want = expected_verdicts.pop_front();
                checked++;
                if (want.case_flags == scc_pkg::C_FLAGS_INVALID)
                    invalid_seen++;
                else if (want.case_flags == scc_pkg::C_FLAGS_LONG)
                    long_seen++;
                else
                    short_seen++;
                if (got.case_flags != want.case_flags
                    || got.name_length != want.name_length
                    || got.ext_length != want.ext_length) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("verdict %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                                 checked, want.case_flags, want.name_length,
                                 want.ext_length, got.case_flags, got.name_length,
                                 got.ext_length);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    scc_in_if  in_ch();
    scc_out_if out_ch();

    short_name_case_classifier #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    short_name_checker chk;
    logic [7:0]        name_bytes[$];
    int unsigned       bytes_sent;
    int unsigned       names_sent;
    int unsigned       cycles;
    int                in_idle_pct;
    int                out_stall_pct;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d verdicts owed", cycles, chk.pending());
            $display("FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        scc_pkg::t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.case_flags  = out_ch.case_flags;
            got.name_length = out_ch.name_length;
            got.ext_length  = out_ch.ext_length;
            chk.check_verdict(got);
        end
    end

    // one byte of the given class
    function automatic logic [7:0] pick_byte(scc_pkg::t_byte_kind k);
        string plain = "0123456789!#$%&'()-@^_`{}~";
        string longs = " +,;=[]";
        string bads  = "\"*/:<>?\\|";
        int    r;
        case (k)
            scc_pkg::K_UPPER:      return 8'(8'h41 + $urandom_range(0, 25));
            scc_pkg::K_LOWER:      return 8'(8'h61 + $urandom_range(0, 25));
            scc_pkg::K_DOT:        return ".";
            scc_pkg::K_FORCE_LONG: return longs[$urandom_range(0, longs.len() - 1)];
            scc_pkg::K_INVALID: begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    return 8'($urandom_range(0, 31));
                else if (r == 19)
                    return 8'h7F;
                else
                    return bads[r - 10];
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return 8'($urandom_range(128, 255));
                else
                    return plain[$urandom_range(0, plain.len() - 1)];
            end
        endcase
    endfunction

    function automatic t_part_case pick_case();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CASE_UPPER;
        else if (r < 8)
            return CASE_LOWER;
        else
            return CASE_MIXED;
    endfunction

    // mostly letters of the part's case, with the odd flaw
    function automatic logic [7:0] part_byte(t_part_case pc);
        int r;
        r = $urandom_range(0, 199);
        if (r < 145) begin
            if (pc == CASE_UPPER || (pc == CASE_MIXED && $urandom_range(0, 1) == 0))
                return pick_byte(scc_pkg::K_UPPER);
            else
                return pick_byte(scc_pkg::K_LOWER);
        end
        if (r < 185)
            return pick_byte(scc_pkg::K_NEUTRAL);
        if (r < 191)
            return pick_byte(scc_pkg::K_FORCE_LONG);
        if (r < 195)
            return pick_byte(scc_pkg::K_INVALID);
        return pick_byte(scc_pkg::K_DOT);
    endfunction

    // next random name: mostly name.ext shaped, some raw noise, two saturating ones
    task automatic build_name();
        int         r;
        int         nlen;
        int         elen;
        bit         has_ext;
        t_part_case nc;
        t_part_case ec;
        name_bytes.delete();
        r = $urandom_range(0, 99);
        if (names_sent == 40) begin
            repeat (270) name_bytes.push_back(pick_byte(scc_pkg::K_LOWER));
        end else if (names_sent == 130) begin
            name_bytes.push_back("Q");
            name_bytes.push_back(".");
            repeat (270) name_bytes.push_back(pick_byte(scc_pkg::K_NEUTRAL));
        end else if (r < 12) begin
            repeat ($urandom_range(1, 8)) name_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            nlen    = $urandom_range(0, 10);
            elen    = $urandom_range(0, 4);
            has_ext = ($urandom_range(0, 9) < 7);
            nc      = pick_case();
            ec      = pick_case();
            repeat (nlen) name_bytes.push_back(part_byte(nc));
            if (has_ext) begin
                name_bytes.push_back(".");
                repeat (elen) name_bytes.push_back(part_byte(ec));
            end
            if (name_bytes.size() == 0)
                name_bytes.push_back(".");
        end
    endtask

    // one byte beat, entered and left at a falling edge
    task automatic send_byte(logic [7:0] c, logic fin);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.last  <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        chk.add_byte(c, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_name();
        foreach (name_bytes[i])
            send_byte(name_bytes[i], i == name_bytes.size() - 1);
        names_sent++;
    endtask

    task automatic send_str(string s);
        name_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            name_bytes.push_back(s[i]);
        send_name();
    endtask

    // hold the sender until every verdict owed has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int          phase;
        int          next_phase;
        int unsigned random_start;
        in_ch.valid   = 1'b0;
        in_ch.ch      = 8'h00;
        in_ch.last    = 1'b0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        in_idle_pct   = IN_IDLE[0];
        out_stall_pct = OUT_STALL[0];
        chk           = new(MAX_LEN);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed names: byte extremes, each byte class and the corner cases
        name_bytes = '{8'h00};
        send_name();
        name_bytes = '{8'hFF};
        send_name();
        send_str("a.B");
        send_str("A.b");
        send_str("aB");
        send_str("a+");
        send_str("a|b");
        send_str(".");
        send_str("a..");
        send_str(".abcd");
        drain();

        // random names through the idling phases
        phase        = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            next_phase = (bytes_sent - random_start) * 4 / RANDOM_BYTES;
            if (next_phase != phase) begin
                drain();
                phase         = next_phase;
                in_idle_pct   = IN_IDLE[phase];
                out_stall_pct = OUT_STALL[phase];
            end
            build_name();
            send_name();
        end
        drain();

        $display("sent %0d byte beats in %0d names across four idling phases",
                 bytes_sent, names_sent);
        $display("checked %0d verdicts (%0d invalid, %0d long, %0d short), %0d bad, %0d owed",
                 chk.checked, chk.invalid_seen, chk.long_seen, chk.short_seen,
                 chk.mismatches, chk.pending());
        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* short_name_case_classifier.f */
rtl/scc_pkg.sv
rtl/scc_in_if.sv
rtl/scc_out_if.sv
rtl/scc_byte_class.sv
rtl/scc_tracker.sv
rtl/short_name_case_classifier.sv
sim/tb_short_name_case_classifier.sv
